@@ design/tcw_pkg.sv @@
// package for the text console writer: action codes, datapath command
// and status structs, cell constants; no dependencies
package tcw_pkg;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam logic [7:0] GLYPH_BLANK    = 8'h20;
  localparam logic [7:0] GLYPH_CURSOR   = 8'h5F;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] COLOR_DEFAULT  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = {COLOR_DEFAULT, GLYPH_BLANK};

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_COLOR = 2'd2,
    ACT_READ  = 2'd3
  } tcw_act_t;

  // write port source
  typedef enum logic [2:0] {
    MW_NONE,
    MW_CHAR,
    MW_UNDER,
    MW_BLANK,
    MW_CURSOR,
    MW_CLR,
    MW_FILL,
    MW_COPY
  } tcw_mw_t;

  // read port address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_CUR,
    RD_SCROLL,
    RD_USER
  } tcw_rd_t;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_ADV,
    POS_NEWLINE,
    POS_BACK,
    POS_HOME
  } tcw_pos_t;

  typedef enum logic [1:0] {
    SW_HOLD,
    SW_ZERO,
    SW_INC,
    SW_FILL
  } tcw_sw_t;

  typedef struct packed {
    logic     load;
    tcw_mw_t  mw;
    tcw_rd_t  rd;
    tcw_pos_t pos;
    tcw_sw_t  sweep;
    logic     color_load;
    logic     color_dflt;
    logic     under_load;
    logic     under_blank;
    logic     shown_set;
    logic     shown_clr;
    logic     scroll_set;
    logic     cell_load;
    logic     out_load;
  } tcw_cmd_t;

  typedef struct packed {
    tcw_act_t act;
    logic     is_newline;
    logic     is_backspace;
    logic     col_zero;
    logic     col_last;
    logic     row_last;
    logic     rd_ok;
    logic     copy_last;
    logic     sweep_last;
  } tcw_sts_t;

endpackage

@@ design/tcw_dp.sv @@
// datapath of the text console writer: cell store, cursor and colour
// registers, sweep counter and result registers; uses tcw_pkg
module tcw_dp #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcw_pkg::tcw_cmd_t         cmd,
  output tcw_pkg::tcw_sts_t         sts,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_char_code,
  input  logic [7:0]                in_new_color,
  input  logic [tcw_pkg::ROW_W-1:0] in_read_row,
  input  logic [tcw_pkg::COL_W-1:0] in_read_col,
  output logic [tcw_pkg::ROW_W-1:0] out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0] out_cursor_col,
  output logic [15:0]               out_cell_word,
  output logic                      out_did_scroll
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0] FILL_BASE = AW'(CELLS - COLS);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);

  logic [CELL_W-1:0] mem [CELLS];

  tcw_act_t          act_r;
  logic [7:0]        ch_r;
  logic [7:0]        newc_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [7:0]        color_r;
  logic [CELL_W-1:0] under_r;
  logic              shown_r;
  logic [AW-1:0]     sweep_r;
  logic              cp_v_r;
  logic [AW-1:0]     cp_a_r;
  logic [CELL_W-1:0] rdata_r;
  logic [CELL_W-1:0] cell_r;
  logic              scroll_r;

  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              out_scroll_r;

  logic [AW-1:0]     cur_idx;
  logic [AW-1:0]     usr_idx;
  logic [7:0]        swapped;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  assign cur_idx = AW'(row_r) * COLS_A + AW'(col_r);
  assign usr_idx = AW'(rrow_r) * COLS_A + AW'(rcol_r);
  assign swapped = {color_r[3:0], color_r[7:4]};

  assign sts.act          = act_r;
  assign sts.is_newline   = (ch_r == CODE_NEWLINE);
  assign sts.is_backspace = (ch_r == CODE_BACKSPACE);
  assign sts.col_zero     = (col_r == '0);
  assign sts.col_last     = (col_r == COL_LAST);
  assign sts.row_last     = (row_r == ROW_LAST);
  assign sts.rd_ok        = (32'(rrow_r) < 32'(ROWS)) && (32'(rcol_r) < 32'(COLS));
  assign sts.copy_last    = (sweep_r == COPY_LAST);
  assign sts.sweep_last   = (sweep_r == CELL_LAST);

  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = {color_r, ch_r};
    unique case (cmd.mw)
      MW_NONE:   we = 1'b0;
      MW_CHAR:   we = 1'b1;
      MW_UNDER: begin
        we    = shown_r;
        wdata = under_r;
      end
      MW_BLANK: begin
        we    = 1'b1;
        wdata = {color_r, GLYPH_BLANK};
      end
      MW_CURSOR: begin
        we    = 1'b1;
        wdata = {swapped, GLYPH_CURSOR};
      end
      MW_CLR: begin
        we    = 1'b1;
        waddr = sweep_r;
        wdata = BLANK_CELL;
      end
      MW_FILL: begin
        we    = 1'b1;
        waddr = sweep_r;
        wdata = {color_r, GLYPH_BLANK};
      end
      MW_COPY: begin
        we    = cp_v_r;
        waddr = cp_a_r;
        wdata = rdata_r;
      end
    endcase
  end

  always_comb begin
    re    = 1'b1;
    raddr = cur_idx;
    unique case (cmd.rd)
      RD_NONE:   re = 1'b0;
      RD_CUR:    raddr = cur_idx;
      RD_SCROLL: raddr = sweep_r + COLS_A;
      RD_USER:   raddr = usr_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    unique case (cmd.pos)
      POS_HOLD: ;
      POS_ADV: begin
        if (sts.col_last) begin
          col_nxt = '0;
          if (!sts.row_last) row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      POS_NEWLINE: begin
        col_nxt = '0;
        if (!sts.row_last) row_nxt = row_r + 1'b1;
      end
      POS_BACK: col_nxt = col_r - 1'b1;
      POS_HOME: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      color_r <= COLOR_DEFAULT;
      under_r <= BLANK_CELL;
      shown_r <= 1'b0;
      sweep_r <= '0;
      cp_v_r  <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      cp_v_r <= (cmd.rd == RD_SCROLL);
      if (cmd.color_dflt) begin
        color_r <= COLOR_DEFAULT;
      end else if (cmd.color_load) begin
        color_r <= newc_r;
      end
      if (cmd.under_blank) begin
        under_r <= BLANK_CELL;
      end else if (cmd.under_load) begin
        under_r <= rdata_r;
      end
      if (cmd.shown_set) begin
        shown_r <= 1'b1;
      end else if (cmd.shown_clr) begin
        shown_r <= 1'b0;
      end
      unique case (cmd.sweep)
        SW_HOLD: ;
        SW_ZERO: sweep_r <= '0;
        SW_INC:  sweep_r <= sweep_r + 1'b1;
        SW_FILL: sweep_r <= FILL_BASE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cp_a_r <= sweep_r;
    if (cmd.load) begin
      act_r    <= tcw_act_t'(in_action);
      ch_r     <= in_char_code;
      newc_r   <= in_new_color;
      rrow_r   <= in_read_row;
      rcol_r   <= in_read_col;
      cell_r   <= '0;
      scroll_r <= 1'b0;
    end else begin
      if (cmd.cell_load) cell_r <= rdata_r;
      if (cmd.scroll_set) scroll_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_row_r    <= ROW_W'(row_r);
      out_col_r    <= COL_W'(col_r);
      out_cell_r   <= cell_r;
      out_scroll_r <= scroll_r;
    end
  end

  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_word  = out_cell_r;
  assign out_did_scroll = out_scroll_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(ROWS)) && (32'(col_r) < 32'(COLS)))
    else $error("cursor outside screen");

  a_cursor_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mw == MW_CURSOR) |=> shown_r)
    else $error("cursor drawn but not marked shown");

  a_copy_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cp_v_r |-> $past(cmd.rd == RD_SCROLL))
    else $error("scroll copy write without matching read");

endmodule

@@ design/tcw_ctrl.sv @@
// controller of the text console writer: sequences each action over the
// datapath and holds the result handshake; uses tcw_pkg
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  output logic              out_valid,
  input  logic              out_stall,
  output tcw_pkg::tcw_cmd_t cmd,
  input  tcw_pkg::tcw_sts_t sts
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BLANK,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_SHOW_RD,
    ST_SHOW_WR,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   rep_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (tcw_act_t'(in_action))
            ACT_PUT, ACT_COLOR: state_nxt = ST_EXEC;
            ACT_CLEAR: begin
              cmd.sweep = SW_ZERO;
              state_nxt = ST_CLEAR;
            end
            ACT_READ: state_nxt = ST_RD_ISSUE;
          endcase
        end
      end
      ST_EXEC: begin
        cmd.shown_clr = 1'b1;
        if (sts.act == ACT_COLOR) begin
          cmd.mw         = MW_UNDER;
          cmd.color_load = 1'b1;
          state_nxt      = ST_SHOW_RD;
        end else begin
          priority if (sts.is_newline) begin
            cmd.mw  = MW_UNDER;
            cmd.pos = POS_NEWLINE;
            if (sts.row_last) begin
              cmd.sweep      = SW_ZERO;
              cmd.scroll_set = 1'b1;
              state_nxt      = ST_COPY;
            end else begin
              state_nxt = ST_SHOW_RD;
            end
          end else if (sts.is_backspace) begin
            cmd.mw = MW_UNDER;
            if (!sts.col_zero) begin
              cmd.pos   = POS_BACK;
              state_nxt = ST_BLANK;
            end else begin
              state_nxt = ST_SHOW_RD;
            end
          end else begin
            cmd.mw  = MW_CHAR;
            cmd.pos = POS_ADV;
            if (sts.col_last && sts.row_last) begin
              cmd.sweep      = SW_ZERO;
              cmd.scroll_set = 1'b1;
              state_nxt      = ST_COPY;
            end else begin
              state_nxt = ST_SHOW_RD;
            end
          end
        end
      end
      ST_BLANK: begin
        cmd.mw    = MW_BLANK;
        state_nxt = ST_SHOW_RD;
      end
      ST_COPY: begin
        cmd.rd    = RD_SCROLL;
        cmd.mw    = MW_COPY;
        cmd.sweep = SW_INC;
        if (sts.copy_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.mw    = MW_COPY;
        cmd.sweep = SW_FILL;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.mw    = MW_FILL;
        cmd.sweep = SW_INC;
        if (sts.sweep_last) state_nxt = ST_SHOW_RD;
      end
      ST_SHOW_RD: begin
        cmd.rd    = RD_CUR;
        state_nxt = ST_SHOW_WR;
      end
      ST_SHOW_WR: begin
        cmd.under_load = 1'b1;
        cmd.mw         = MW_CURSOR;
        cmd.shown_set  = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_RD_ISSUE: begin
        if (sts.rd_ok) cmd.rd = RD_USER;
        state_nxt = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        cmd.cell_load = sts.rd_ok;
        state_nxt     = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.mw    = MW_CLR;
        cmd.sweep = SW_INC;
        if (sts.sweep_last) begin
          cmd.pos         = POS_HOME;
          cmd.color_dflt  = 1'b1;
          cmd.under_blank = 1'b1;
          cmd.shown_clr   = 1'b1;
          state_nxt       = rep_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      rep_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) rep_r <= 1'b1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_copy_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |=> (state_r == ST_COPY || state_r == ST_DRAIN))
    else $error("scroll copy left early");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while busy");

endmodule

@@ design/text_mode_console_writer_top.sv @@
// top level of the text console writer: controller plus datapath
// depends on tcw_pkg, tcw_ctrl and tcw_dp
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | action, char_code, new_color, read_row, read_col
//   out_    | output    | out_valid / out_stall | cursor_row, cursor_col, cell_word, did_scroll
//
// a put runs the exec, cursor read, cursor write and done states before its result
// (a backspace that moves adds a blank state), set colour likewise, read an issue,
// a wait and the done state; a scroll copies rows 1 to ROWS-1 up one row, cell by cell
// over the separate store read and write ports, then blanks the last row
// clear blanks the store, one cell blanked per cycle; after reset it is blanked before in_stall drops
// a stalled result stays in its register; the next transaction is taken meanwhile
module text_mode_console_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_char_code,
  input  logic [7:0]                in_new_color,
  input  logic [tcw_pkg::ROW_W-1:0] in_read_row,
  input  logic [tcw_pkg::COL_W-1:0] in_read_col,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tcw_pkg::ROW_W-1:0] out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0] out_cursor_col,
  output logic [15:0]               out_cell_word,
  output logic                      out_did_scroll
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tcw_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_new_color   (in_new_color),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_word  (out_cell_word),
    .out_did_scroll (out_did_scroll)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for text_mode_console_writer_top: directed, wrap/scroll,
// random and backpressure tests checked against a behavioral screen predictor
// depends on tcw_pkg and the design sources
`timescale 1ns / 100ps

module tb_top;
  import tcw_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int SCREEN_CELLS   = ROWS * COLS;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int DRAIN_CYCLES   = 32;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] word;
    logic              scroll;
  } console_res_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_action;
  logic [7:0]        in_char_code;
  logic [7:0]        in_new_color;
  logic [ROW_W-1:0]  in_read_row;
  logic [COL_W-1:0]  in_read_col;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic [15:0]       out_cell_word;
  logic              out_did_scroll;

  // screen predictor state
  logic [CELL_W-1:0] screen_model [SCREEN_CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [7:0]        cur_color;
  logic [CELL_W-1:0] saved_cell;
  bit                glyph_on;

  console_res_t pending_results [$];
  console_res_t want;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len    = 0;
  int hold_token  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;

  int mismatch_count = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int scroll_count   = 0;
  int clear_count    = 0;
  int read_count     = 0;

  text_mode_console_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_new_color   (in_new_color),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_word  (out_cell_word),
    .out_did_scroll (out_did_scroll)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void screen_reset();
    int i;
    for (i = 0; i < SCREEN_CELLS; i++) screen_model[i] = BLANK_CELL;
    cur_row   = 0;
    cur_col   = 0;
    cur_color = COLOR_DEFAULT;
    saved_cell = BLANK_CELL;
    glyph_on  = 1'b0;
  endfunction

  function automatic void put_back_cell();
    if (glyph_on) begin
      screen_model[cur_row * COLS + cur_col] = saved_cell;
      glyph_on = 1'b0;
    end
  endfunction

  function automatic void show_glyph();
    int idx;
    idx = cur_row * COLS + cur_col;
    saved_cell = screen_model[idx];
    screen_model[idx] = {cur_color[3:0], cur_color[7:4], GLYPH_CURSOR};
    glyph_on = 1'b1;
  endfunction

  function automatic bit line_feed();
    int i;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (i = 0; i < SCREEN_CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (i = SCREEN_CELLS - COLS; i < SCREEN_CELLS; i++)
        screen_model[i] = {cur_color, GLYPH_BLANK};
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_res_t console_step(tcw_act_t act, logic [7:0] ch,
                                                logic [7:0] nc, logic [ROW_W-1:0] rr,
                                                logic [COL_W-1:0] rc);
    console_res_t res;
    res = '0;
    case (act)
      ACT_PUT: begin
        put_back_cell();
        if (ch == CODE_NEWLINE) begin
          cur_col = 0;
          res.scroll = line_feed();
        end else if (ch == CODE_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_model[cur_row * COLS + cur_col] = {cur_color, GLYPH_BLANK};
          end
        end else begin
          screen_model[cur_row * COLS + cur_col] = {cur_color, ch};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            res.scroll = line_feed();
          end
        end
        show_glyph();
      end
      ACT_CLEAR: screen_reset();
      ACT_COLOR: begin
        put_back_cell();
        cur_color = nc;
        show_glyph();
      end
      default: begin
        if (rr < ROWS && rc < COLS) res.word = screen_model[rr * COLS + rc];
      end
    endcase
    res.row = ROW_W'(cur_row);
    res.col = COL_W'(cur_col);
    return res;
  endfunction

  task automatic send_action(tcw_act_t act, logic [7:0] ch, logic [7:0] nc,
                             logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    @(negedge clk);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_action    = act;
    in_char_code = ch;
    in_new_color = nc;
    in_read_row  = rr;
    in_read_col  = rc;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(console_step(act, ch, nc, rr, rc));
    sent_count++;
    if (act == ACT_CLEAR) clear_count++;
    if (act == ACT_READ) read_count++;
  endtask

  task automatic put_char(logic [7:0] ch);
    send_action(ACT_PUT, ch, 8'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic set_color(logic [7:0] nc);
    send_action(ACT_COLOR, 8'($urandom), nc, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_cell(int rr, int rc);
    send_action(ACT_READ, 8'($urandom), 8'($urandom), ROW_W'(rr), COL_W'(rc));
  endtask

  task automatic clear_screen();
    send_action(ACT_CLEAR, 8'($urandom), 8'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_basics();
    read_cell(0, 0);
    put_char(CODE_BACKSPACE);
    read_cell(0, 0);
    set_color(8'h00);
    set_color(8'hFF);
    set_color(8'hF0);
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    read_cell(0, 0);
    read_cell(0, 2);
    read_cell(0, 3);
    put_char(CODE_BACKSPACE);
    read_cell(0, 2);
    put_char(CODE_NEWLINE);
    read_cell(1, 0);
    read_cell(ROWS - 1, COLS - 1);
    read_cell(31, 127);
    read_cell(0, COLS);
    read_cell(ROWS, 0);
    clear_screen();
    read_cell(0, 0);
    put_char(8'h5A);
    read_cell(0, 0);
    read_cell(0, 1);
  endtask

  task automatic test_line_wrap_and_scroll();
    int i;
    clear_screen();
    for (i = 0; i < COLS; i++) put_char(8'($urandom_range(8'h7E, 8'h21)));
    read_cell(0, COLS - 1);
    read_cell(1, 0);
    set_color(8'h1E);
    for (i = 1; i < ROWS - 1; i++) put_char(CODE_NEWLINE);
    put_char(8'h2A);
    put_char(CODE_NEWLINE);
    read_cell(ROWS - 2, 0);
    read_cell(ROWS - 1, 5);
    for (i = 0; i < COLS; i++) put_char(8'($urandom));
    read_cell(ROWS - 2, COLS - 1);
    read_cell(ROWS - 1, 0);
    read_cell(ROWS - 1, 1);
  endtask

  task automatic test_random_traffic(int count);
    int n;
    int pick;
    int kind;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(999);
      if (pick < 560) put_char(8'($urandom));
      else if (pick < 700) put_char(CODE_NEWLINE);
      else if (pick < 780) put_char(CODE_BACKSPACE);
      else if (pick < 855) set_color(8'($urandom));
      else if (pick < 860) clear_screen();
      else begin
        kind = $urandom_range(4);
        case (kind)
          0, 1: read_cell(cur_row, cur_col);
          2: read_cell(cur_row, $urandom_range(COLS - 1));
          3: read_cell($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
          default: read_cell($urandom_range(31), $urandom_range(127));
        endcase
      end
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    hold_len = 400;
    hold_token++;
    for (n = 0; n < 40; n++) begin
      if (n % 5 == 4) read_cell(cur_row, cur_col);
      else if (n % 7 == 6) set_color(8'($urandom));
      else put_char(8'($urandom));
    end
  endtask

  // receiver stall generator
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, expected none actual row %0d col %0d cell %h",
                 $time, out_cursor_row, out_cursor_col, out_cell_word);
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_row", want.row, out_cursor_row);
        check_field("cursor_col", want.col, out_cursor_col);
        check_field("cell_word", want.word, out_cell_word);
        check_field("did_scroll", want.scroll, out_did_scroll);
        checked_count++;
        if (out_did_scroll === 1'b1) scroll_count++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_PUT;
    in_char_code = '0;
    in_new_color = '0;
    in_read_row  = '0;
    in_read_col  = '0;
    screen_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 19;
    rx_idle_pct = 46;
    test_directed_basics();
    test_line_wrap_and_scroll();
    test_random_traffic(130);

    tx_idle_pct = 46;
    rx_idle_pct = 19;
    test_random_traffic(150);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(140);
    test_output_backpressure();

    wait_drained();
    $display("covered %0d transactions in, %0d results checked", sent_count, checked_count);
    $display("including %0d scrolls, %0d clears and %0d cell reads",
             scroll_count, clear_count, read_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
